// ----- design/sehp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sehp_pkg: shared constants for the squared-error / hinge-penalty loss block
// Field widths, register indexes and saturation limits used by the
// interfaces, the total-loss pipeline and the top level.
// ----------------------------------------------------------------------------
package sehp_pkg;

	// channel field widths
	localparam int PIX_W          = 16;
	localparam int CFG_IDX_BITS   = 8;
	localparam int CFG_DATA_BITS  = 16;
	localparam int SUM_BITS_OUT   = 52;
	localparam int TOTAL_BITS     = 61;

	// Q8.8 weight: fraction bits dropped after weight * penalty
	localparam int WEIGHT_FRAC_BITS = 8;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_BITS-1:0] REG_PENALTY_WEIGHT = 8'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_HINGE_LEVEL    = 8'd1;

	// reset values of the registers
	localparam logic [CFG_DATA_BITS-1:0] WEIGHT_RESET    = 16'd0;
	localparam logic [CFG_DATA_BITS-1:0] THRESHOLD_RESET = 16'd16384;

	// output saturation limits
	localparam logic [SUM_BITS_OUT-1:0] SUM_MAX   = '1;
	localparam logic [TOTAL_BITS-1:0]   TOTAL_MAX = '1;

endpackage

// ----- design/sehp_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sehp_ifs: valid/ready channels of the loss block
// Pixel input channel, loss result channel and register write channel.
// ----------------------------------------------------------------------------
interface sehp_pixel_if;
	import sehp_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] wafer_pixel;
	logic [PIX_W-1:0] target_pixel;
	logic             last_pixel;

	modport source (output valid, wafer_pixel, target_pixel, last_pixel, input ready);
	modport sink   (input valid, wafer_pixel, target_pixel, last_pixel, output ready);
endinterface

interface sehp_loss_if;
	import sehp_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [SUM_BITS_OUT-1:0] error_sum;
	logic [SUM_BITS_OUT-1:0] penalty_sum;
	logic [TOTAL_BITS-1:0]   total_loss;

	modport source (output valid, error_sum, penalty_sum, total_loss, input ready);
	modport sink   (input valid, error_sum, penalty_sum, total_loss, output ready);
endinterface

interface sehp_cfg_if;
	import sehp_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/squared_error_with_hinge_penalty.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// squared_error_with_hinge_penalty: streaming image loss
// Sums squared wafer/target differences and a hinge penalty on background
// pixels, and reports both sums and the weighted total per image.
// ----------------------------------------------------------------------------
// Usage:
//   pixels : one wafer/target pixel pair per transfer; last_pixel closes an
//            image. One pixel is taken every cycle while the pipe flows.
//   losses : one transfer per image, carrying error_sum, penalty_sum and
//            total_loss (all with 30 fraction bits, saturating).
//   cfg    : register writes, index 0 = penalty_weight (Q8.8),
//            index 1 = hinge threshold tau (Q1.15). Always ready; write only
//            while no image is in flight. Other indexes are ignored.
// Timing: throughput is one pixel per cycle while the pipe flows. The result of
//   an image is valid after its last pixel has passed the input register, square
//   stage, accumulate, two multiply stages and the final add into the output
//   register. Squares and sums are each one short stage.
// Reset: clears both accumulators and all valid flags; weight resets to 0,
//   threshold to 0.5.
// Stall: while losses is held, the result waits in the output register and
//   pixel transfers go on until the next image result backs up the pipe.
// ----------------------------------------------------------------------------
module squared_error_with_hinge_penalty #(
	parameter int PIXEL_BITS = 16,
	parameter int ACC_BITS   = 52
) (
	input  logic       clk,
	input  logic       arst_n,
	sehp_cfg_if.sink   cfg,
	sehp_pixel_if.sink pixels,
	sehp_loss_if.source losses
);
	import sehp_pkg::*;

	localparam int SQ_BITS  = 2 * PIXEL_BITS;
	localparam int IN_BITS  = (PIX_W > PIXEL_BITS) ? PIX_W : PIXEL_BITS;
	localparam int CMP_BITS = (CFG_DATA_BITS > PIXEL_BITS) ? CFG_DATA_BITS : PIXEL_BITS;
	localparam int ADD_BITS = ((ACC_BITS > SQ_BITS) ? ACC_BITS : SQ_BITS) + 1;
	localparam logic [ACC_BITS-1:0] ACC_MAX = '1;

	logic [CFG_DATA_BITS-1:0] weight_q;
	logic [CFG_DATA_BITS-1:0] threshold_q;

	// stage 1: input register
	logic                  valid_s1;
	logic [PIXEL_BITS-1:0] wafer_s1;
	logic [PIXEL_BITS-1:0] target_s1;
	logic                  last_s1;
	// stage 2: squares
	logic               valid_s2;
	logic [SQ_BITS-1:0] err_sq_s2;
	logic [SQ_BITS-1:0] pen_sq_s2;
	logic               last_s2;

	logic [ACC_BITS-1:0] err_acc_q;
	logic [ACC_BITS-1:0] pen_acc_q;

	logic s1_ready, s2_ready, take_s2, tot_ready;

	logic [IN_BITS-1:0]    wafer_in;
	logic [IN_BITS-1:0]    target_in;
	logic [PIXEL_BITS-1:0] diff;
	logic [CMP_BITS-1:0]   wafer_cmp;
	logic [CMP_BITS-1:0]   thr_cmp;
	logic [CMP_BITS-1:0]   excess_full;
	logic [PIXEL_BITS-1:0] excess;
	logic                  background;
	logic                  hinge_hit;
	logic [SQ_BITS-1:0]    err_sq;
	logic [SQ_BITS-1:0]    pen_sq;
	logic [ADD_BITS-1:0]   err_add;
	logic [ADD_BITS-1:0]   pen_add;
	logic [ACC_BITS-1:0]   err_next;
	logic [ACC_BITS-1:0]   pen_next;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q    <= WEIGHT_RESET;
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PENALTY_WEIGHT: weight_q    <= cfg.data;
				REG_HINGE_LEVEL:    threshold_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// handshake: an item in stage 2 leaves at once unless it closes an image and the total pipeline is not ready
	assign take_s2      = valid_s2 && (!last_s2 || tot_ready);
	assign s2_ready     = !valid_s2 || take_s2;
	assign s1_ready     = !valid_s1 || s2_ready;
	assign pixels.ready = s1_ready;

	assign wafer_in  = IN_BITS'(pixels.wafer_pixel);
	assign target_in = IN_BITS'(pixels.target_pixel);

	// squares of the difference and of the hinge excess
	always_comb begin
		diff        = (wafer_s1 >= target_s1) ? (wafer_s1 - target_s1)
			: (target_s1 - wafer_s1);
		wafer_cmp   = CMP_BITS'(wafer_s1);
		thr_cmp     = CMP_BITS'(threshold_q);
		background  = (target_s1[PIXEL_BITS-1 -: 2] == 2'b00);
		hinge_hit   = background && (wafer_cmp > thr_cmp);
		excess_full = wafer_cmp - thr_cmp;
		excess      = excess_full[PIXEL_BITS-1:0];
		err_sq      = SQ_BITS'(diff) * SQ_BITS'(diff);
		pen_sq      = hinge_hit ? (SQ_BITS'(excess) * SQ_BITS'(excess)) : '0;
	end

	// saturating accumulation
	always_comb begin
		err_add  = ADD_BITS'(err_acc_q) + ADD_BITS'(err_sq_s2);
		pen_add  = ADD_BITS'(pen_acc_q) + ADD_BITS'(pen_sq_s2);
		err_next = (|err_add[ADD_BITS-1:ACC_BITS]) ? ACC_MAX : err_add[ACC_BITS-1:0];
		pen_next = (|pen_add[ADD_BITS-1:ACC_BITS]) ? ACC_MAX : pen_add[ACC_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			err_acc_q <= '0;
			pen_acc_q <= '0;
		end else begin
			if (s1_ready) valid_s1 <= pixels.valid;
			if (s2_ready) valid_s2 <= valid_s1;
			if (take_s2) begin
				// drop the sums once an image closes
				if (last_s2) begin
					err_acc_q <= '0;
					pen_acc_q <= '0;
				end else begin
					err_acc_q <= err_next;
					pen_acc_q <= pen_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && pixels.valid) begin
			wafer_s1  <= wafer_in[PIXEL_BITS-1:0];
			target_s1 <= target_in[PIXEL_BITS-1:0];
			last_s1   <= pixels.last_pixel;
		end
		if (s2_ready && valid_s1) begin
			err_sq_s2 <= err_sq;
			pen_sq_s2 <= pen_sq;
			last_s2   <= last_s1;
		end
	end

	sehp_total #(
		.ACC_BITS(ACC_BITS)
	) u_total (
		.clk       (clk),
		.arst_n    (arst_n),
		.weight    (weight_q),
		.sums_valid(valid_s2 && last_s2),
		.sums_ready(tot_ready),
		.err_in    (err_next),
		.pen_in    (pen_next),
		.losses    (losses)
	);

endmodule

// ----- design/sehp_total.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sehp_total: weighted total-loss pipeline
// Takes the final error and penalty sums of one image, forms
// error + floor(weight * penalty / 256) with saturation over three stages
// and holds the result in an output register for the loss channel.
// ----------------------------------------------------------------------------
module sehp_total #(
	parameter int ACC_BITS = 52
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [sehp_pkg::CFG_DATA_BITS-1:0] weight,
	input  logic                               sums_valid,
	output logic                               sums_ready,
	input  logic [ACC_BITS-1:0]                err_in,
	input  logic [ACC_BITS-1:0]                pen_in,
	sehp_loss_if.source                        losses
);
	import sehp_pkg::*;

	localparam int LO_BITS   = 32;
	localparam int HI_BITS   = ACC_BITS - LO_BITS;
	localparam int PLO_BITS  = CFG_DATA_BITS + LO_BITS;
	localparam int PHI_BITS  = CFG_DATA_BITS + HI_BITS;
	localparam int PROD_BITS = CFG_DATA_BITS + ACC_BITS;
	localparam int WIDE_BITS = 80;
	localparam int ADD_BITS  = 64;

	// stage 3: final sums
	logic                valid_s3;
	logic [ACC_BITS-1:0] err_s3;
	logic [ACC_BITS-1:0] pen_s3;
	// stage 4: partial products
	logic                valid_s4;
	logic [ACC_BITS-1:0] err_s4;
	logic [ACC_BITS-1:0] pen_s4;
	logic [PLO_BITS-1:0] plo_s4;
	logic [PHI_BITS-1:0] phi_s4;
	// stage 5: clamped weighted penalty
	logic                  valid_s5;
	logic [ACC_BITS-1:0]   err_s5;
	logic [ACC_BITS-1:0]   pen_s5;
	logic [TOTAL_BITS-1:0] wpen_s5;
	// output register
	logic                    out_valid_q;
	logic [SUM_BITS_OUT-1:0] error_sum_q;
	logic [SUM_BITS_OUT-1:0] penalty_sum_q;
	logic [TOTAL_BITS-1:0]   total_loss_q;

	logic out_ready, s5_ready, s4_ready, s3_ready;

	logic [PLO_BITS-1:0]   plo;
	logic [PHI_BITS-1:0]   phi;
	logic [PROD_BITS-1:0]  prod_full;
	logic [WIDE_BITS-1:0]  wpen_wide;
	logic [TOTAL_BITS-1:0] wpen;
	logic [ADD_BITS-1:0]   err_ext;
	logic [ADD_BITS-1:0]   pen_ext;
	logic [ADD_BITS-1:0]   total_sum;

	assign out_ready  = !out_valid_q || losses.ready;
	assign s5_ready   = !valid_s5 || out_ready;
	assign s4_ready   = !valid_s4 || s5_ready;
	assign s3_ready   = !valid_s3 || s4_ready;
	assign sums_ready = s3_ready;

	// weight times penalty, split at bit 32 of the penalty sum
	assign plo = PLO_BITS'(weight) * PLO_BITS'(pen_s3[LO_BITS-1:0]);
	assign phi = PHI_BITS'(weight) * PHI_BITS'(pen_s3[ACC_BITS-1:LO_BITS]);

	// recombine, drop the Q8.8 fraction and clamp to the total width
	always_comb begin
		prod_full = (PROD_BITS'(phi_s4) << LO_BITS) + PROD_BITS'(plo_s4);
		wpen_wide = WIDE_BITS'(prod_full >> WEIGHT_FRAC_BITS);
		wpen      = (wpen_wide > WIDE_BITS'(TOTAL_MAX)) ? TOTAL_MAX
			: wpen_wide[TOTAL_BITS-1:0];
	end

	assign err_ext   = ADD_BITS'(err_s5);
	assign pen_ext   = ADD_BITS'(pen_s5);
	assign total_sum = err_ext + ADD_BITS'(wpen_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s3_ready) valid_s3 <= sums_valid;
			if (s4_ready) valid_s4 <= valid_s3;
			if (s5_ready) valid_s5 <= valid_s4;
			if (out_ready) out_valid_q <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_ready && sums_valid) begin
			err_s3 <= err_in;
			pen_s3 <= pen_in;
		end
		if (s4_ready && valid_s3) begin
			err_s4 <= err_s3;
			pen_s4 <= pen_s3;
			plo_s4 <= plo;
			phi_s4 <= phi;
		end
		if (s5_ready && valid_s4) begin
			err_s5  <= err_s4;
			pen_s5  <= pen_s4;
			wpen_s5 <= wpen;
		end
		if (out_ready && valid_s5) begin
			error_sum_q   <= (err_ext > ADD_BITS'(SUM_MAX)) ? SUM_MAX
				: err_ext[SUM_BITS_OUT-1:0];
			penalty_sum_q <= (pen_ext > ADD_BITS'(SUM_MAX)) ? SUM_MAX
				: pen_ext[SUM_BITS_OUT-1:0];
			total_loss_q  <= (total_sum > ADD_BITS'(TOTAL_MAX)) ? TOTAL_MAX
				: total_sum[TOTAL_BITS-1:0];
		end
	end

	assign losses.valid       = out_valid_q;
	assign losses.error_sum   = error_sum_q;
	assign losses.penalty_sum = penalty_sum_q;
	assign losses.total_loss  = total_loss_q;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for squared_error_with_hinge_penalty
// Streams images of wafer/target pixel pairs under random source gaps and
// sink stalls. A scoreboard predicts the error sum, penalty sum and weighted
// total of every image and checks each loss transfer field by field.
// Register settings change between images only while the block is empty.
// ----------------------------------------------------------------------------
module tb;
	import sehp_pkg::*;

	localparam int ACC_BITS      = 52;
	localparam int HALF_LEVEL    = 1 << (PIX_W - 2);
	localparam int PIPE_LATENCY  = 5;
	localparam int SETTLE_CYCLES = 2 * PIPE_LATENCY;
	localparam int IDLE_LIMIT    = 5000;
	localparam int RANDOM_PIXELS = 2000;
	localparam logic [ACC_BITS-1:0] ACC_MAX = '1;

	typedef struct {
		logic [SUM_BITS_OUT-1:0] error_sum;
		logic [SUM_BITS_OUT-1:0] penalty_sum;
		logic [TOTAL_BITS-1:0]   total_loss;
	} image_loss_t;

	class image_loss_board;
		logic [CFG_DATA_BITS-1:0] weight;
		logic [CFG_DATA_BITS-1:0] threshold;
		logic [ACC_BITS-1:0]      err_acc;
		logic [ACC_BITS-1:0]      pen_acc;
		image_loss_t              expected_losses[$];
		int                       mismatches;

		function new();
			weight     = WEIGHT_RESET;
			threshold  = THRESHOLD_RESET;
			err_acc    = '0;
			pen_acc    = '0;
			mismatches = 0;
		endfunction

		function void write_register(logic [CFG_IDX_BITS-1:0] idx,
			logic [CFG_DATA_BITS-1:0] data);
			case (idx)
				REG_PENALTY_WEIGHT: begin
					weight = data;
				end
				REG_HINGE_LEVEL: begin
					threshold = data;
				end
				default: begin
				end
			endcase
		endfunction

		function logic [ACC_BITS-1:0] sat_add(logic [ACC_BITS-1:0] acc,
			logic [2*PIX_W-1:0] sq);
			logic [ACC_BITS:0] s;
			s = acc + sq;
			return (s > ACC_MAX) ? ACC_MAX : s[ACC_BITS-1:0];
		endfunction

		function void note_pixel(logic [PIX_W-1:0] wafer, logic [PIX_W-1:0] target,
			logic last);
			logic [PIX_W-1:0]   diff;
			logic [PIX_W-1:0]   excess;
			logic [2*PIX_W-1:0] sq;
			logic [68:0]        weighted;
			logic [69:0]        total;
			image_loss_t        loss;
			diff    = (wafer >= target) ? wafer - target : target - wafer;
			sq      = diff * diff;
			err_acc = sat_add(err_acc, sq);
			// hinge: only background targets, only wafer strictly above tau
			if (target < HALF_LEVEL && wafer > threshold) begin
				excess  = wafer - threshold;
				sq      = excess * excess;
				pen_acc = sat_add(pen_acc, sq);
			end
			if (last) begin
				weighted = weight * pen_acc;
				weighted = weighted >> WEIGHT_FRAC_BITS;
				total    = err_acc + weighted;
				// accumulators are as wide as the output sums, so no clamp needed
				loss.error_sum   = err_acc;
				loss.penalty_sum = pen_acc;
				loss.total_loss  = (total > TOTAL_MAX) ? TOTAL_MAX : total[TOTAL_BITS-1:0];
				expected_losses.push_back(loss);
				err_acc = '0;
				pen_acc = '0;
			end
		endfunction

		function void check_loss(logic [SUM_BITS_OUT-1:0] error_sum,
			logic [SUM_BITS_OUT-1:0] penalty_sum, logic [TOTAL_BITS-1:0] total_loss);
			image_loss_t want;
			if (expected_losses.size() == 0) begin
				$error("loss transfer with no image pending: error_sum %0d", error_sum);
				mismatches++;
			end else begin
				want = expected_losses.pop_front();
				if (error_sum !== want.error_sum) begin
					$error("error_sum: expected %0d, got %0d", want.error_sum, error_sum);
					mismatches++;
				end
				if (penalty_sum !== want.penalty_sum) begin
					$error("penalty_sum: expected %0d, got %0d", want.penalty_sum, penalty_sum);
					mismatches++;
				end
				if (total_loss !== want.total_loss) begin
					$error("total_loss: expected %0d, got %0d", want.total_loss, total_loss);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;

	sehp_cfg_if   cfg_if ();
	sehp_pixel_if pix_if ();
	sehp_loss_if  loss_if ();

	image_loss_board board;
	bit              steady;
	int              pixels_sent;
	int              idle_cycles;

	squared_error_with_hinge_penalty DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.pixels (pix_if),
		.losses (loss_if)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	function logic [PIX_W-1:0] pick_pixel();
		logic [PIX_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = '1;
			2: v = PIX_W'(board.threshold + $urandom_range(0, 2) - 1);
			3: v = PIX_W'(HALF_LEVEL - $urandom_range(0, 1));
			default: v = PIX_W'($urandom);
		endcase
		return v;
	endfunction

	function logic [PIX_W-1:0] pick_target();
		if ($urandom_range(0, 1))
			return PIX_W'($urandom_range(0, HALF_LEVEL - 1));
		else
			return pick_pixel();
	endfunction

	task send_pixel(input logic [PIX_W-1:0] wafer, input logic [PIX_W-1:0] target,
		input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			pix_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_if.valid        <= 1'b1;
		pix_if.wafer_pixel  <= wafer;
		pix_if.target_pixel <= target;
		pix_if.last_pixel   <= last;
		do @(posedge clk); while (!pix_if.ready);
		pixels_sent++;
	endtask

	task send_image(input int len);
		for (int i = 0; i < len; i++)
			send_pixel(pick_pixel(), pick_target(), i == len - 1);
	endtask

	// drop valid, wait for every pending image result, then let the pipe empty
	task settle();
		pix_if.valid <= 1'b0;
		@(posedge clk);
		while (board.expected_losses.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_DATA_BITS-1:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= data;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	// loss sink: runs of ready broken by stalls, some of them long
	initial begin
		int run;
		int gap;
		forever begin
			loss_if.ready <= 1'b1;
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 6);
			repeat (run) @(posedge clk);
			gap = $urandom_range(0, 99);
			gap = (gap < 50) ? 0 : (gap < 88) ? $urandom_range(1, 3) : $urandom_range(10, 30);
			if (gap > 0) begin
				loss_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// transfer monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (pix_if.valid && pix_if.ready)
				board.note_pixel(pix_if.wafer_pixel, pix_if.target_pixel, pix_if.last_pixel);
			if (cfg_if.valid && cfg_if.ready)
				board.write_register(cfg_if.index, cfg_if.data);
			if (loss_if.valid && loss_if.ready)
				board.check_loss(loss_if.error_sum, loss_if.penalty_sum, loss_if.total_loss);
			if ((pix_if.valid && pix_if.ready) || (cfg_if.valid && cfg_if.ready) ||
				(loss_if.valid && loss_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		int random_start;
		int images;
		int len;
		board       = new();
		steady      = 1'b0;
		pixels_sent = 0;
		idle_cycles = 0;
		pix_if.valid        <= 1'b0;
		pix_if.wafer_pixel  <= '0;
		pix_if.target_pixel <= '0;
		pix_if.last_pixel   <= 1'b0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= '0;
		cfg_if.data  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: weight 0, threshold one half
		send_pixel(16'h0000, 16'h0000, 1'b1);
		send_pixel(16'hFFFF, 16'h0000, 1'b1);
		send_pixel(16'h0000, 16'hFFFF, 1'b1);
		send_pixel(16'd16384, 16'h0000, 1'b0);
		send_pixel(16'd16385, 16'd16383, 1'b0);
		send_pixel(16'd30000, 16'd16384, 1'b0);
		send_pixel(16'hFFFF, 16'hFFFF, 1'b1);
		settle();

		write_reg(REG_PENALTY_WEIGHT, 16'hFFFF);
		write_reg(REG_HINGE_LEVEL, 16'h0000);
		send_pixel(16'hFFFF, 16'h0000, 1'b0);
		send_pixel(16'h0001, 16'd16383, 1'b0);
		send_pixel(16'h0000, 16'h0000, 1'b1);
		settle();

		write_reg(REG_PENALTY_WEIGHT, 16'd256);
		write_reg(REG_HINGE_LEVEL, 16'hFFFF);
		send_pixel(16'hFFFF, 16'h0000, 1'b1);
		settle();

		// a penalty of one lsb must floor away under weight 1/256
		write_reg(REG_PENALTY_WEIGHT, 16'd1);
		write_reg(REG_HINGE_LEVEL, 16'd16384);
		send_pixel(16'd16385, 16'h0000, 1'b1);
		settle();

		random_start = pixels_sent;
		while (pixels_sent - random_start < RANDOM_PIXELS) begin
			case ($urandom_range(0, 3))
				0: write_reg(REG_PENALTY_WEIGHT, 16'h0000);
				1: write_reg(REG_PENALTY_WEIGHT, 16'hFFFF);
				default: write_reg(REG_PENALTY_WEIGHT, CFG_DATA_BITS'($urandom));
			endcase
			case ($urandom_range(0, 4))
				0: write_reg(REG_HINGE_LEVEL, 16'h0000);
				1: write_reg(REG_HINGE_LEVEL, 16'hFFFF);
				2: write_reg(REG_HINGE_LEVEL, THRESHOLD_RESET);
				default: write_reg(REG_HINGE_LEVEL, CFG_DATA_BITS'($urandom));
			endcase
			// unmapped index: must leave both registers alone
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_IDX_BITS'($urandom_range(2, 255)), CFG_DATA_BITS'($urandom));
			steady = ($urandom_range(0, 4) == 0);
			images = $urandom_range(2, 8);
			for (int n = 0; n < images; n++) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
				send_image(len);
			end
			steady = 1'b0;
			settle();
		end

		if (board.mismatches == 0 && board.expected_losses.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/sehp_pkg.sv
design/sehp_ifs.sv
design/sehp_total.sv
design/squared_error_with_hinge_penalty.sv
tb/sv/tb.sv
